>>> src/cbc_pkg.sv
`timescale 1ns / 1ps
// cbc_pkg: shared types and constants for the cartridge bank controller
// no dependencies; used by the interfaces and every module under src

package cbc_pkg;

    // access kind on the bus channel
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // widths that the bus and result fields fix
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int ROM_ADDR_W = 21;
    localparam int ROM_BANK_W = 7;
    localparam int RAM_BANK_W = 2;
    localparam int RAM_IDX_W  = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [DATA_W-1:0]     READ_IDLE_BYTE = 8'hFF;
    localparam logic [CFG_DATA_W-1:0] RAM_BANK_BYTES = 16'h2000;

    // region code of a transaction
    typedef enum logic [1:0] {
        REGION_ROM  = 2'd0,
        REGION_RAM  = 2'd1,
        REGION_NONE = 2'd2
    } region_t;

    // mapper register area, address bits 14:13 of a write below 0x8000
    typedef enum logic [1:0] {
        AREA_RAM_ENABLE = 2'd0,
        AREA_ROM_LOW    = 2'd1,
        AREA_UPPER      = 2'd2,
        AREA_MODE       = 2'd3
    } area_t;

    // configuration register index
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROM_BANK_COUNT = 1'b0,
        CFG_RAM_SIZE       = 1'b1
    } cfg_reg_t;

    // decode of one accepted transaction, mapper to datapath
    typedef struct packed {
        logic                  ram_wr;
        logic                  ram_rd;
        logic [RAM_IDX_W-1:0]  ram_idx;
        logic [ROM_ADDR_W-1:0] rom_address;
        region_t               region;
        logic                  bad_bank;
    } access_ctl_t;

endpackage

>>> src/cbc_access_if.sv
`timescale 1ns / 1ps
// cbc_access_if: bus access channel (func, address, data) with valid/ready
// depends on cbc_pkg

interface cbc_access_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [cbc_pkg::ADDR_W-1:0]  address;
    logic [cbc_pkg::DATA_W-1:0]  data;

    modport source (output valid, output func, output address, output data, input ready);
    modport sink   (input valid, input func, input address, input data, output ready);
endinterface

>>> src/cbc_result_if.sv
`timescale 1ns / 1ps
// cbc_result_if: result channel of the controller with valid/ready
// depends on cbc_pkg

interface cbc_result_if;
    logic                            valid;
    logic                            ready;
    logic [cbc_pkg::DATA_W-1:0]      read_data;
    logic [cbc_pkg::ROM_ADDR_W-1:0]  rom_address;
    logic [1:0]                      region;
    logic                            bad_bank;

    modport source (output valid, output read_data, output rom_address, output region,
                    output bad_bank, input ready);
    modport sink   (input valid, input read_data, input rom_address, input region,
                    input bad_bank, output ready);
endinterface

>>> src/cbc_cfg_if.sv
`timescale 1ns / 1ps
// cbc_cfg_if: configuration write channel (index, wdata) with valid/ready
// depends on cbc_pkg

interface cbc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cbc_pkg::CFG_IDX_W-1:0]   index;
    logic [cbc_pkg::CFG_DATA_W-1:0]  wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> src/cbc_ram.sv
`timescale 1ns / 1ps
// cbc_ram: cartridge RAM store, one write or one registered read per cycle
// depends on cbc_pkg

module cbc_ram #(
    parameter int RAM_BYTES = 32768
) (
    input  logic                       clk,
    input  logic                       wr,
    input  logic                       rd,
    input  logic [$clog2(RAM_BYTES)-1:0] idx,
    input  logic [cbc_pkg::DATA_W-1:0] wdata,
    output logic [cbc_pkg::DATA_W-1:0] rdata
);

    logic [cbc_pkg::DATA_W-1:0] mem [RAM_BYTES];
    logic [cbc_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[idx] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd)
        begin
            rdata_reg <= mem[idx];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/cbc_mapper.sv
`timescale 1ns / 1ps
// cbc_mapper: bank select state, configuration registers and access decode
// depends on cbc_pkg and cbc_cfg_if

module cbc_mapper #(
    parameter int RAM_BYTES     = 32768,
    parameter int ROM_BANKS_MAX = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    cbc_cfg_if.sink                     cfg,
    input  logic                        accept,
    input  logic                        func,
    input  logic [cbc_pkg::ADDR_W-1:0]  address,
    input  logic [cbc_pkg::DATA_W-1:0]  data,
    output cbc_pkg::access_ctl_t        ctl
);

    localparam logic [cbc_pkg::CFG_DATA_W-1:0] RamBytes16 = cbc_pkg::CFG_DATA_W'(RAM_BYTES);
    localparam logic [7:0]                     RomBanks8  = 8'(ROM_BANKS_MAX);

    logic [7:0]                        rom_bank_count_reg;
    logic [cbc_pkg::CFG_DATA_W-1:0]    ram_size_reg;

    logic [cbc_pkg::ROM_BANK_W-1:0]    rom_sel_reg, rom_sel_next;
    logic [cbc_pkg::RAM_BANK_W-1:0]    ram_sel_reg, ram_sel_next;
    logic                              ram_mode_reg, ram_mode_next;
    logic                              ram_enable_reg, ram_enable_next;
    logic [cbc_pkg::ROM_BANK_W-1:0]    mapped_rom_reg, mapped_rom_next;
    logic [cbc_pkg::RAM_BANK_W-1:0]    mapped_ram_reg, mapped_ram_next;

    logic [7:0]                        eff_rom_banks;
    logic [cbc_pkg::CFG_DATA_W-1:0]    eff_ram_size;
    logic                              ram_banked;
    cbc_pkg::area_t                    area;
    logic [cbc_pkg::ROM_BANK_W-1:0]    rom_cand;
    logic [cbc_pkg::ROM_BANK_W-1:0]    rom_bumped;
    logic                              rom_bad;
    logic                              ram_bad;
    logic [cbc_pkg::RAM_BANK_W-1:0]    ram_bank;
    logic [cbc_pkg::RAM_IDX_W-1:0]     phys;
    logic                              grant;
    logic                              is_wr;

    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_count_reg <= 8'd2;
            ram_size_reg       <= '0;
        end
        else if (cfg.valid)
        begin
            case (cbc_pkg::cfg_reg_t'(cfg.index))
                cbc_pkg::CFG_ROM_BANK_COUNT: rom_bank_count_reg <= cfg.wdata[7:0];
                cbc_pkg::CFG_RAM_SIZE:       ram_size_reg       <= cfg.wdata;
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_sel_reg    <= '0;
            ram_sel_reg    <= '0;
            ram_mode_reg   <= 1'b0;
            ram_enable_reg <= 1'b0;
            mapped_rom_reg <= cbc_pkg::ROM_BANK_W'(1);
            mapped_ram_reg <= '0;
        end
        else if (accept)
        begin
            rom_sel_reg    <= rom_sel_next;
            ram_sel_reg    <= ram_sel_next;
            ram_mode_reg   <= ram_mode_next;
            ram_enable_reg <= ram_enable_next;
            mapped_rom_reg <= mapped_rom_next;
            mapped_ram_reg <= mapped_ram_next;
        end
    end

    // clamped sizes
    assign eff_rom_banks = (rom_bank_count_reg > RomBanks8) ? RomBanks8 : rom_bank_count_reg;
    assign eff_ram_size  = (ram_size_reg > RamBytes16) ? RamBytes16 : ram_size_reg;
    assign ram_banked    = (eff_ram_size > cbc_pkg::RAM_BANK_BYTES);

    assign area  = cbc_pkg::area_t'(address[14:13]);
    assign is_wr = (func == cbc_pkg::FUNC_WRITE);

    // rom bank candidate, bumped when the low five bits are zero
    always_comb
    begin
        if (area == cbc_pkg::AREA_ROM_LOW)
        begin
            rom_cand = {rom_sel_reg[6:5], data[4:0]};
        end
        else
        begin
            rom_cand = {data[1:0], rom_sel_reg[4:0]};
        end
        rom_bumped = rom_cand;
        if (rom_cand[4:0] == 5'd0)
        begin
            rom_bumped[0] = 1'b1;
        end
        rom_bad = ({1'b0, rom_bumped} >= eff_rom_banks);
    end

    // ram bank check against size / 8 KiB
    assign ram_bad = ram_banked && ({1'b0, data[1:0]} >= eff_ram_size[15:13]);

    // ram window gating
    assign ram_bank = ram_banked ? mapped_ram_reg : '0;
    assign phys     = {ram_bank, address[12:0]};
    assign grant    = ram_enable_reg && ({1'b0, phys} < eff_ram_size)
                      && ({1'b0, phys} < RamBytes16);

    always_comb
    begin
        rom_sel_next    = rom_sel_reg;
        ram_sel_next    = ram_sel_reg;
        ram_mode_next   = ram_mode_reg;
        ram_enable_next = ram_enable_reg;
        mapped_rom_next = mapped_rom_reg;
        mapped_ram_next = mapped_ram_reg;

        ctl             = '0;
        ctl.region      = cbc_pkg::REGION_NONE;
        ctl.ram_idx     = phys;

        if (!address[15])
        begin
            ctl.region = cbc_pkg::REGION_ROM;
            if (!is_wr)
            begin
                ctl.rom_address = {(address[14] ? mapped_rom_reg : 7'd0), address[13:0]};
            end
            else
            begin
                case (area)
                    cbc_pkg::AREA_RAM_ENABLE:
                    begin
                        ram_enable_next = (data[3:0] == 4'hA);
                    end
                    cbc_pkg::AREA_ROM_LOW:
                    begin
                        rom_sel_next = rom_bumped;
                        ctl.bad_bank = rom_bad;
                        if (!rom_bad)
                        begin
                            mapped_rom_next = rom_bumped;
                        end
                    end
                    cbc_pkg::AREA_UPPER:
                    begin
                        if (ram_mode_reg)
                        begin
                            ram_sel_next = data[1:0];
                            ctl.bad_bank = ram_bad;
                            if (!ram_banked)
                            begin
                                mapped_ram_next = '0;
                            end
                            else if (!ram_bad)
                            begin
                                mapped_ram_next = data[1:0];
                            end
                        end
                        else
                        begin
                            rom_sel_next = rom_bumped;
                            ctl.bad_bank = rom_bad;
                            if (!rom_bad)
                            begin
                                mapped_rom_next = rom_bumped;
                            end
                        end
                    end
                    cbc_pkg::AREA_MODE:
                    begin
                        if (data[0])
                        begin
                            ram_mode_next = 1'b1;
                            rom_sel_next  = {2'b00, rom_sel_reg[4:0]};
                        end
                        else
                        begin
                            ram_mode_next = 1'b0;
                            ram_sel_next  = '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
        else if (address[15:13] == 3'b101)
        begin
            ctl.region = cbc_pkg::REGION_RAM;
            ctl.ram_wr = accept && grant && is_wr;
            ctl.ram_rd = accept && grant && !is_wr;
        end
    end

endmodule

>>> src/cartridge_bank_controller.sv
`timescale 1ns / 1ps
// cartridge_bank_controller: top level of the bank controller, two-stage datapath
// depends on cbc_pkg, the cbc_*_if interfaces, cbc_mapper and cbc_ram
//
// usage
//   bus: one transaction per CPU access (func 0 read / 1 write, address, data)
//   result: one transaction per bus transaction, in order: read_data, rom_address,
//     region and bad_bank
//   cfg: writes index 0 (rom_bank_count) or 1 (ram_size_bytes); always ready,
//     only meant to be written while no bus transaction is in flight
// timing
//   a bus transaction is taken every cycle when the result side keeps up;
//   the accepting edge loads stage 1 and the cartridge RAM read port, and the
//   result register loads from them when stage 1 moves on; result.valid is
//   driven by the result register (RAM read port, then the result register)
//   mapper state and RAM writes take effect at the accepting edge, so the
//   next transaction sees them without a bubble
// reset
//   bank selects, mode and RAM enable clear, mapped ROM bank is 1,
//   rom_bank_count 2 and ram_size_bytes 0; RAM contents are not cleared
// stall
//   with result.ready low the result register holds, the stage behind it
//   fills, and then bus.ready drops; no transaction is lost or repeated

module cartridge_bank_controller #(
    parameter int RAM_BYTES     = 32768,
    parameter int ROM_BANKS_MAX = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    cbc_access_if.sink    bus,
    cbc_result_if.source  result,
    cbc_cfg_if.sink       cfg
);

    localparam int RamAw = $clog2(RAM_BYTES);

    cbc_pkg::access_ctl_t               ctl;
    logic                               accept;
    logic [cbc_pkg::DATA_W-1:0]         ram_rdata;

    // stage 1: decoded transaction waiting beside the RAM read data
    logic                               s1_valid_reg;
    logic                               s1_grant_reg;
    logic [cbc_pkg::ROM_ADDR_W-1:0]     s1_rom_address_reg;
    cbc_pkg::region_t                   s1_region_reg;
    logic                               s1_bad_bank_reg;
    logic                               s1_move;

    // result register
    logic                               out_valid_reg;
    logic [cbc_pkg::DATA_W-1:0]         out_read_data_reg;
    logic [cbc_pkg::ROM_ADDR_W-1:0]     out_rom_address_reg;
    cbc_pkg::region_t                   out_region_reg;
    logic                               out_bad_bank_reg;

    // stage 1 advances whenever the result register is empty or being drained
    assign s1_move   = s1_valid_reg && (!out_valid_reg || result.ready);
    assign bus.ready = !s1_valid_reg || s1_move;
    assign accept    = bus.valid && bus.ready;

    cbc_mapper #(
        .RAM_BYTES     (RAM_BYTES),
        .ROM_BANKS_MAX (ROM_BANKS_MAX)
    ) u_mapper (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .accept  (accept),
        .func    (bus.func),
        .address (bus.address),
        .data    (bus.data),
        .ctl     (ctl)
    );

    // read data only reloads on an accepted read, so it holds while stage 1 waits
    cbc_ram #(
        .RAM_BYTES (RAM_BYTES)
    ) u_ram (
        .clk   (clk),
        .wr    (ctl.ram_wr),
        .rd    (ctl.ram_rd),
        .idx   (ctl.ram_idx[RamAw-1:0]),
        .wdata (bus.data),
        .rdata (ram_rdata)
    );

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_grant_reg       <= ctl.ram_rd;
            s1_rom_address_reg <= ctl.rom_address;
            s1_region_reg      <= ctl.region;
            s1_bad_bank_reg    <= ctl.bad_bank;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload; writes and gated or non-RAM reads give the idle byte
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_read_data_reg   <= s1_grant_reg ? ram_rdata : cbc_pkg::READ_IDLE_BYTE;
            out_rom_address_reg <= s1_rom_address_reg;
            out_region_reg      <= s1_region_reg;
            out_bad_bank_reg    <= s1_bad_bank_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.read_data   = out_read_data_reg;
    assign result.rom_address = out_rom_address_reg;
    assign result.region      = out_region_reg;
    assign result.bad_bank    = out_bad_bank_reg;

endmodule

>>> tb/cartridge_bank_controller_tb.sv
`timescale 1ns / 1ps
// cartridge_bank_controller_tb: self-checking testbench of the cartridge bank controller
// depends on cbc_pkg, the cbc_access_if / cbc_result_if / cbc_cfg_if interfaces and the rtl top

module cartridge_bank_controller_tb;

    localparam int unsigned RAM_BYTES     = 32768;
    localparam int unsigned ROM_BANKS_MAX = 128;
    localparam int unsigned QUIET_LIMIT   = 5000;  // cycles with no transaction at all
    localparam int          END_CYCLES    = 8;     // result lags the bus by stage 1 and the result register

    // one bus transaction and one result transaction
    typedef struct packed {
        logic                       func;
        logic [cbc_pkg::ADDR_W-1:0] address;
        logic [cbc_pkg::DATA_W-1:0] data;
    } access_t;

    typedef struct packed {
        logic [cbc_pkg::DATA_W-1:0]     read_data;
        logic [cbc_pkg::ROM_ADDR_W-1:0] rom_address;
        cbc_pkg::region_t               region;
        logic                           bad_bank;
    } outcome_t;

    logic clk;
    logic rst_n;

    cbc_access_if bus_ch ();
    cbc_result_if result_ch ();
    cbc_cfg_if    cfg_ch ();

    cartridge_bank_controller #(
        .RAM_BYTES     (RAM_BYTES),
        .ROM_BANKS_MAX (ROM_BANKS_MAX)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .bus    (bus_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // mapper shadow: configuration, bank selects, mapping and the ram image
    // ------------------------------------------------------------------
    logic [7:0]                     cfg_rom_banks;
    logic [cbc_pkg::CFG_DATA_W-1:0] cfg_ram_size;
    logic [6:0]                     rom_sel;
    logic [1:0]                     ram_sel;
    logic                           mode_ram;
    logic                           ram_en;
    logic [6:0]                     rom_map;
    logic [1:0]                     ram_map;
    logic [cbc_pkg::DATA_W-1:0]     ram_image [0:RAM_BYTES-1];

    access_t     access_queue [$];   // bus transactions not yet driven
    outcome_t    outcome_queue [$];  // results owed by accepted bus transactions
    access_t     access_on_bus;
    int unsigned send_idle;          // percent of cycles the bus side holds back
    int unsigned recv_idle;          // percent of cycles the result side stalls
    int unsigned errors;
    int unsigned quiet_cycles;

    // oversized registers are clamped to what the block supports
    function automatic int unsigned rom_banks_eff();
        int unsigned n;
        n = 32'(cfg_rom_banks);
        return (n > ROM_BANKS_MAX) ? ROM_BANKS_MAX : n;
    endfunction

    function automatic int unsigned ram_size_eff();
        int unsigned n;
        n = 32'(cfg_ram_size);
        return (n > RAM_BYTES) ? RAM_BYTES : n;
    endfunction

    // bump a zero low field, keep the old mapping on a missing bank
    function automatic logic remap_rom();
        if (rom_sel[4:0] == 5'd0)
            rom_sel = rom_sel + 7'd1;
        if (32'(rom_sel) >= rom_banks_eff())
            return 1'b1;
        rom_map = rom_sel;
        return 1'b0;
    endfunction

    // one ram bank or none: always bank 0
    function automatic logic remap_ram();
        int unsigned size;
        int unsigned bank_bytes;
        size       = ram_size_eff();
        bank_bytes = 32'(cbc_pkg::RAM_BANK_BYTES);
        if (size <= bank_bytes)
        begin
            ram_map = 2'd0;
            return 1'b0;
        end
        if (32'(ram_sel) >= size / bank_bytes)
            return 1'b1;
        ram_map = ram_sel;
        return 1'b0;
    endfunction

    // result of one bus transaction, updating the shadow state
    function automatic outcome_t map_access(access_t a);
        outcome_t    o;
        logic [6:0]  bank;
        logic [14:0] idx;
        int unsigned size;
        int unsigned bank_bytes;
        int unsigned phys;
        o.read_data   = cbc_pkg::READ_IDLE_BYTE;
        o.rom_address = '0;
        o.region      = cbc_pkg::REGION_NONE;
        o.bad_bank    = 1'b0;
        if (a.address < 16'h8000)
        begin
            o.region = cbc_pkg::REGION_ROM;
            if (a.func == cbc_pkg::FUNC_READ)
            begin
                bank          = a.address[14] ? rom_map : 7'd0;
                o.rom_address = {bank, a.address[13:0]};
            end
            else
            begin
                case (cbc_pkg::area_t'(a.address[14:13]))
                    cbc_pkg::AREA_RAM_ENABLE:
                        ram_en = (a.data[3:0] == 4'hA);
                    cbc_pkg::AREA_ROM_LOW:
                    begin
                        rom_sel    = {rom_sel[6:5], a.data[4:0]};
                        o.bad_bank = remap_rom();
                    end
                    cbc_pkg::AREA_UPPER:
                    begin
                        if (mode_ram)
                        begin
                            ram_sel    = a.data[1:0];
                            o.bad_bank = remap_ram();
                        end
                        else
                        begin
                            rom_sel    = {a.data[1:0], rom_sel[4:0]};
                            o.bad_bank = remap_rom();
                        end
                    end
                    default:
                    begin
                        if (a.data[0])
                        begin
                            mode_ram     = 1'b1;
                            rom_sel[6:5] = 2'b00;
                        end
                        else
                        begin
                            mode_ram = 1'b0;
                            ram_sel  = 2'd0;
                        end
                    end
                endcase
            end
        end
        else if (a.address >= 16'hA000 && a.address < 16'hC000)
        begin
            o.region   = cbc_pkg::REGION_RAM;
            size       = ram_size_eff();
            bank_bytes = 32'(cbc_pkg::RAM_BANK_BYTES);
            phys       = (size > bank_bytes ? 32'(ram_map) : 32'd0) * bank_bytes
                         + 32'(a.address[12:0]);
            if (ram_en && phys < size)
            begin
                idx = 15'(phys);
                if (a.func == cbc_pkg::FUNC_WRITE)
                    ram_image[idx] = a.data;
                else
                    o.read_data = ram_image[idx];
            end
        end
        return o;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_access(logic f, logic [cbc_pkg::ADDR_W-1:0] a,
                                         logic [cbc_pkg::DATA_W-1:0] d);
        access_t item;
        item.func    = f;
        item.address = a;
        item.data    = d;
        access_queue.push_back(item);
    endfunction

    // ram window traffic stays on four groups of 16 offsets per bank:
    // both ends of the window and both sides of the 4 KiB point
    function automatic logic [8:0] ram_group(int unsigned g);
        case (g)
            0:       return 9'h000;
            1:       return 9'h0FF;
            2:       return 9'h100;
            default: return 9'h1FF;
        endcase
    endfunction

    function automatic logic [12:0] ram_offset();
        return {ram_group($urandom_range(0, 3)), 4'($urandom_range(0, 15))};
    endfunction

    // mostly rom reads, mapper programming and ram window traffic, some fully random noise
    function automatic access_t random_access();
        access_t a;
        a.func    = 1'($urandom_range(0, 1));
        a.address = 16'($urandom_range(0, 16'hFFFF));
        a.data    = 8'($urandom_range(0, 8'hFF));
        case ($urandom_range(0, 9))
            0, 1:
            begin
                a.func    = cbc_pkg::FUNC_READ;
                a.address = 16'($urandom_range(0, 16'h7FFF));
            end
            2:
            begin
                // ram enable area, mostly with the enable nibble
                a.func    = cbc_pkg::FUNC_WRITE;
                a.address = 16'($urandom_range(0, 16'h1FFF));
                if ($urandom_range(0, 3) != 0)
                    a.data[3:0] = 4'hA;
            end
            3:
            begin
                a.func    = cbc_pkg::FUNC_WRITE;
                a.address = 16'($urandom_range(16'h2000, 16'h5FFF));
            end
            4:
            begin
                a.func    = cbc_pkg::FUNC_WRITE;
                a.address = 16'($urandom_range(16'h6000, 16'h7FFF));
            end
            5, 6, 7, 8:
                a.address = 16'hA000;
            default:
                ;
        endcase
        // keep ram window traffic on offsets that were filled
        if (a.address[15:13] == 3'b101)
            a.address = {3'b101, ram_offset()};
        return a;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    // one configuration transaction, shadow updated at the accepting edge
    task automatic write_register(input cbc_pkg::cfg_reg_t idx,
                                  input logic [cbc_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == cbc_pkg::CFG_ROM_BANK_COUNT)
            cfg_rom_banks = value[7:0];
        else
            cfg_ram_size = value;
    endtask

    // every queued transaction driven, accepted and answered; checked at the
    // falling edge so the driver's updates of the same rising edge are settled
    task automatic wait_drained();
        while (access_queue.size() != 0 || bus_ch.valid || outcome_queue.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // bus driver: predicts each transaction at the edge that accepts it
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (bus_ch.valid && bus_ch.ready)
                outcome_queue.push_back(map_access(access_on_bus));
            // free to present the next item unless one is still waiting
            if (!bus_ch.valid || bus_ch.ready)
            begin
                if (access_queue.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    access_on_bus   = access_queue.pop_front();
                    bus_ch.valid   <= 1'b1;
                    bus_ch.func    <= access_on_bus.func;
                    bus_ch.address <= access_on_bus.address;
                    bus_ch.data    <= access_on_bus.data;
                end
                else
                    bus_ch.valid <= 1'b0;
            end
        end
        else
        begin
            bus_ch.valid   <= 1'b0;
            bus_ch.func    <= cbc_pkg::FUNC_READ;
            bus_ch.address <= '0;
            bus_ch.data    <= '0;
        end
    end

    // ------------------------------------------------------------------
    // result monitor: random stalls, in-order compare against the oldest owed result
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        outcome_t want;
        outcome_t got;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.read_data   = result_ch.read_data;
                got.rom_address = result_ch.rom_address;
                got.region      = cbc_pkg::region_t'(result_ch.region);
                got.bad_bank    = result_ch.bad_bank;
                if (outcome_queue.size() == 0)
                    flag_error($sformatf("unexpected result transaction: rd %02h rom %06h",
                                         got.read_data, got.rom_address));
                else
                begin
                    want = outcome_queue.pop_front();
                    if (got.read_data !== want.read_data
                        || got.rom_address !== want.rom_address
                        || got.region !== want.region
                        || got.bad_bank !== want.bad_bank)
                        flag_error($sformatf({"mismatch: expected rd %02h rom %06h region %0d",
                                              " bad %0d, got rd %02h rom %06h region %0d bad %0d"},
                                             want.read_data, want.rom_address, want.region,
                                             want.bad_bank, got.read_data, got.rom_address,
                                             got.region, got.bad_bank));
                end
            end
            result_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // watchdog: cycles in which no transaction moves on any channel
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (bus_ch.valid && bus_ch.ready)
            || (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [cbc_pkg::CFG_DATA_W-1:0] rom_cfg;
        logic [cbc_pkg::CFG_DATA_W-1:0] ram_cfg;

        // known values on the configuration inputs from time zero
        rst_n        <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= cbc_pkg::CFG_ROM_BANK_COUNT;
        cfg_ch.wdata <= '0;
        send_idle    = 7;
        recv_idle    = 53;

        // reset state of the mapper
        cfg_rom_banks = 8'd2;
        cfg_ram_size  = '0;
        rom_sel       = '0;
        ram_sel       = '0;
        mode_ram      = 1'b0;
        ram_en        = 1'b0;
        rom_map       = 7'd1;
        ram_map       = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // ram contents are undefined after reset: write every offset that the
        // traffic reads, in all four banks, before any read of the window
        write_register(cbc_pkg::CFG_RAM_SIZE, 16'd32768);
        write_register(cbc_pkg::CFG_ROM_BANK_COUNT, 16'd128);
        queue_access(cbc_pkg::FUNC_WRITE, 16'h0000, 8'h0A);
        queue_access(cbc_pkg::FUNC_WRITE, 16'h6000, 8'h01);
        for (int b = 0; b < 4; b++)
        begin
            queue_access(cbc_pkg::FUNC_WRITE, 16'h4000, 8'(b));
            for (int g = 0; g < 4; g++)
                for (int l = 0; l < 16; l++)
                    queue_access(cbc_pkg::FUNC_WRITE, {3'b101, ram_group(g), 4'(l)},
                                 8'($urandom_range(0, 8'hFF)));
        end
        wait_drained();

        // directed: eight rom banks, two ram banks
        send_idle = 7;
        recv_idle = 53;
        write_register(cbc_pkg::CFG_ROM_BANK_COUNT, 16'd8);
        write_register(cbc_pkg::CFG_RAM_SIZE, 16'h4000);
        // rom window edges, bank 0 fixed below 0x4000
        queue_access(cbc_pkg::FUNC_READ,  16'h0000, 8'h00);
        queue_access(cbc_pkg::FUNC_READ,  16'h3FFF, 8'hFF);
        queue_access(cbc_pkg::FUNC_READ,  16'h4000, 8'h00);
        queue_access(cbc_pkg::FUNC_READ,  16'h7FFF, 8'h00);
        // low rom bits: last bank, missing bank, zero bumped to one
        queue_access(cbc_pkg::FUNC_WRITE, 16'h2000, 8'h07);
        queue_access(cbc_pkg::FUNC_READ,  16'h4000, 8'h00);
        queue_access(cbc_pkg::FUNC_WRITE, 16'h3FFF, 8'h08);
        queue_access(cbc_pkg::FUNC_WRITE, 16'h2000, 8'h00);
        // rom mode: upper bits reach past the bank count, 0x60 bumps to 0x61
        queue_access(cbc_pkg::FUNC_WRITE, 16'h7FFF, 8'hFE);
        queue_access(cbc_pkg::FUNC_WRITE, 16'h4000, 8'h03);
        queue_access(cbc_pkg::FUNC_WRITE, 16'h2000, 8'hE0);
        // ram mode clears rom bits 6:5, then a good and a missing ram bank
        queue_access(cbc_pkg::FUNC_WRITE, 16'h6000, 8'h01);
        queue_access(cbc_pkg::FUNC_WRITE, 16'h4000, 8'h01);
        queue_access(cbc_pkg::FUNC_WRITE, 16'h5FFF, 8'h02);
        // enable needs only the low nibble 0xA
        queue_access(cbc_pkg::FUNC_WRITE, 16'h1FFF, 8'hFA);
        queue_access(cbc_pkg::FUNC_READ,  16'hA000, 8'h00);
        queue_access(cbc_pkg::FUNC_READ,  16'hBFFF, 8'h00);
        queue_access(cbc_pkg::FUNC_WRITE, 16'hA123, 8'h5C);
        queue_access(cbc_pkg::FUNC_READ,  16'hA123, 8'h00);
        // neither window
        queue_access(cbc_pkg::FUNC_READ,  16'h8000, 8'h00);
        queue_access(cbc_pkg::FUNC_READ,  16'h9FFF, 8'h00);
        queue_access(cbc_pkg::FUNC_WRITE, 16'hC000, 8'h11);
        queue_access(cbc_pkg::FUNC_READ,  16'hFFFF, 8'h00);
        // disabled ram: reads give the idle byte, writes dropped
        queue_access(cbc_pkg::FUNC_WRITE, 16'h0000, 8'h0B);
        queue_access(cbc_pkg::FUNC_WRITE, 16'hA000, 8'h99);
        queue_access(cbc_pkg::FUNC_READ,  16'hA000, 8'h00);
        wait_drained();

        // random phases, each under its own register setting
        for (int p = 0; p < 6; p++)
        begin
            if (p < 2)
            begin
                send_idle = 7;
                recv_idle = 53;
            end
            else if (p < 4)
            begin
                send_idle = 53;
                recv_idle = 7;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (p)
                0:       begin rom_cfg = 16'd2;   ram_cfg = 16'd0;     end
                1:       begin rom_cfg = 16'd128; ram_cfg = 16'd32768; end
                2:       begin rom_cfg = 16'd255; ram_cfg = 16'hFFFF;  end
                3:       begin rom_cfg = 16'd1;   ram_cfg = 16'h3000;  end
                4:       begin rom_cfg = 16'd0;   ram_cfg = 16'h2000;  end
                default: begin
                    rom_cfg = 16'($urandom_range(2, 128));
                    ram_cfg = 16'($urandom_range(0, 32768));
                end
            endcase
            write_register(cbc_pkg::CFG_ROM_BANK_COUNT, rom_cfg);
            write_register(cbc_pkg::CFG_RAM_SIZE, ram_cfg);
            // the bus side pauses halfway until every result is back
            repeat (100) access_queue.push_back(random_access());
            wait_drained();
            repeat (100) access_queue.push_back(random_access());
            wait_drained();
        end

        // let any stray result show up before the verdict
        repeat (END_CYCLES) @(posedge clk);
        if (outcome_queue.size() != 0)
            flag_error($sformatf("%0d results never arrived", outcome_queue.size()));
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
